// ----- rtl/clc_pkg.sv -----
// ----------------------------------------------------------------------------
// clc_pkg
// Shared widths and sideband type for the circle contact pipeline.
// ----------------------------------------------------------------------------
package clc_pkg;

  // displacement after pre-shift, magnitude, radius sum
  localparam int D_W    = 25;
  localparam int R_W    = 24;
  localparam int L_W    = 50;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 34;
  localparam int DREM_W = 33;
  localparam int SQRT_GUARD = 7;

  // fields that ride along with each beat
  typedef struct packed {
    logic           hit;
    logic           neg_x;
    logic           neg_y;
    logic [D_W-1:0] ux;
    logic [D_W-1:0] uy;
    logic [R_W-1:0] r;
  } side_t;

endpackage

// ----- rtl/circle_overlap_contact_core.sv -----
// ----------------------------------------------------------------------------
// circle_overlap_contact_core
// Narrow-phase circle/circle contact: hit flag, unit normal and depth.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one circle pair per beat;
//   output channel (out_valid/out_ready) returns one contact per beat.
//   The pipeline has three front stages for displacement, squares and
//   overlap compare, one stage per root bit of the 32-bit square root,
//   one stage per quotient bit of the normal divider, and one output
//   stage for rounding, clamping and depth.
//   Throughput is one beat per cycle unless the output stalls;
//   every stage holds one pair. When the receiver stalls with a
//   result pending, the whole pipeline holds and in_ready drops;
//   nothing is lost or repeated.
//   Reset clears every valid bit; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module circle_overlap_contact_core #(
  parameter int COORD_BITS       = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] first_center_x,
  input  logic [COORD_BITS-1:0] first_center_y,
  input  logic [COORD_BITS-2:0] first_radius,
  input  logic [COORD_BITS-1:0] second_center_x,
  input  logic [COORD_BITS-1:0] second_center_y,
  input  logic [COORD_BITS-2:0] second_radius,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [15:0]           normal_x,
  output logic [15:0]           normal_y,
  output logic [23:0]           depth
);
  import clc_pkg::*;

  localparam int QW        = NORMAL_FRAC_BITS + 2;
  localparam int PRE_SHIFT = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;
  localparam int NSQ       = ROOT_W;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // front stages
  logic             f_valid;
  side_t            f_side;
  logic [RAD_W-1:0] f_rad;

  clc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .en(adv), .in_valid,
    .ax(first_center_x), .ay(first_center_y), .ar(first_radius),
    .bx(second_center_x), .by(second_center_y), .br(second_radius),
    .out_valid(f_valid), .out_side(f_side), .out_rad(f_rad)
  );

  // square root chain
  logic              q_valid [0:NSQ];
  side_t             q_side  [0:NSQ];
  logic [RAD_W-1:0]  q_rad   [0:NSQ];
  logic [REM_W-1:0]  q_rem   [0:NSQ];
  logic [ROOT_W-1:0] q_root  [0:NSQ];

  assign q_valid[0] = f_valid;
  assign q_side[0]  = f_side;
  assign q_rad[0]   = f_rad;
  assign q_rem[0]   = '0;
  assign q_root[0]  = '0;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    clc_sqrt_stage u_stage (
      .clk, .rst, .en(adv),
      .in_valid(q_valid[i]), .in_side(q_side[i]), .in_rad(q_rad[i]),
      .in_rem(q_rem[i]), .in_root(q_root[i]),
      .out_valid(q_valid[i+1]), .out_side(q_side[i+1]), .out_rad(q_rad[i+1]),
      .out_rem(q_rem[i+1]), .out_root(q_root[i+1])
    );
  end

  // divider chain: remainder starts at magnitude * 64, below the root
  logic              d_valid [0:QW];
  side_t             d_side  [0:QW];
  logic [ROOT_W-1:0] d_s     [0:QW];
  logic [DREM_W-1:0] d_rem_x [0:QW];
  logic [DREM_W-1:0] d_rem_y [0:QW];
  logic [QW-1:0]     d_qx    [0:QW];
  logic [QW-1:0]     d_qy    [0:QW];

  assign d_valid[0] = q_valid[NSQ];
  assign d_side[0]  = q_side[NSQ];
  assign d_s[0]     = q_root[NSQ];
  assign d_rem_x[0] = DREM_W'(q_side[NSQ].ux) << 6;
  assign d_rem_y[0] = DREM_W'(q_side[NSQ].uy) << 6;
  assign d_qx[0]    = '0;
  assign d_qy[0]    = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    clc_div_stage #(.QW(QW)) u_stage (
      .clk, .rst, .en(adv),
      .in_valid(d_valid[j]), .in_side(d_side[j]), .in_s(d_s[j]),
      .in_rem_x(d_rem_x[j]), .in_rem_y(d_rem_y[j]),
      .in_qx(d_qx[j]), .in_qy(d_qy[j]),
      .out_valid(d_valid[j+1]), .out_side(d_side[j+1]), .out_s(d_s[j+1]),
      .out_rem_x(d_rem_x[j+1]), .out_rem_y(d_rem_y[j+1]),
      .out_qx(d_qx[j+1]), .out_qy(d_qy[j+1])
    );
  end

  // round, clamp, sign and depth
  side_t        e_side;
  logic [QW:0]  rx, ry, lim;
  logic [63:0]  mx, my, vx, vy, dep;
  logic         nz;

  always_comb begin
    e_side = d_side[QW];
    nz     = e_side.hit && (d_s[QW] != '0);
    lim    = (QW+1)'(1) << NORMAL_FRAC_BITS;
    rx     = ((QW+1)'(d_qx[QW]) + 1'b1) >> 1;
    ry     = ((QW+1)'(d_qy[QW]) + 1'b1) >> 1;
    if (rx > lim) rx = lim;
    if (ry > lim) ry = lim;
    mx     = nz ? 64'(rx) : 64'd0;
    my     = nz ? 64'(ry) : 64'd0;
    vx     = e_side.neg_x ? (~mx + 64'd1) : mx;
    vy     = e_side.neg_y ? (~my + 64'd1) : my;
    dep    = e_side.hit
             ? ((64'(e_side.r) - 64'(d_s[QW] >> SQRT_GUARD)) << PRE_SHIFT)
             : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit      <= e_side.hit;
      normal_x <= vx[15:0];
      normal_y <= vy[15:0];
      depth    <= dep[23:0];
    end
  end

  // checks
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> normal_x == 16'd0 && normal_y == 16'd0 && depth == 24'd0)
    else $error("nonzero contact fields on a miss");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(depth) && $stable(normal_x))
    else $error("stalled result changed");

endmodule

// ----- rtl/clc_front.sv -----
// ----------------------------------------------------------------------------
// clc_front
// Displacement, squares and overlap test: three register stages.
// ----------------------------------------------------------------------------
module clc_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [COORD_BITS-1:0]     ax,
  input  logic [COORD_BITS-1:0]     ay,
  input  logic [COORD_BITS-2:0]     ar,
  input  logic [COORD_BITS-1:0]     bx,
  input  logic [COORD_BITS-1:0]     by,
  input  logic [COORD_BITS-2:0]     br,
  output logic                      out_valid,
  output clc_pkg::side_t            out_side,
  output logic [clc_pkg::RAD_W-1:0] out_rad
);
  import clc_pkg::*;

  localparam int PRE_SHIFT = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;

  logic signed [32:0] dx_full, dy_full, dx_sh, dy_sh;
  logic [32:0]        rsum;
  logic [D_W-1:0]     dx_t, dy_t;

  logic               v1, v2, v3;
  side_t              side1, side2, side3;
  side_t              side1_next;
  side_t              side3_next;
  logic [2*D_W-1:0]   sq_x, sq_y;
  logic [2*R_W-1:0]   sq_r;
  logic [RAD_W-1:0]   rad;
  logic [L_W-1:0]     l_sum;

  // form displacement, pre-shift, magnitude and radius sum
  always_comb begin
    dx_full = 33'(signed'(bx)) - 33'(signed'(ax));
    dy_full = 33'(signed'(by)) - 33'(signed'(ay));
    dx_sh   = dx_full >>> PRE_SHIFT;
    dy_sh   = dy_full >>> PRE_SHIFT;
    dx_t    = dx_sh[D_W-1:0];
    dy_t    = dy_sh[D_W-1:0];
    rsum    = (33'(ar) + 33'(br)) >> PRE_SHIFT;
    side1_next.hit   = 1'b0;
    side1_next.neg_x = dx_t[D_W-1];
    side1_next.neg_y = dy_t[D_W-1];
    side1_next.ux    = dx_t[D_W-1] ? (~dx_t + 1'b1) : dx_t;
    side1_next.uy    = dy_t[D_W-1] ? (~dy_t + 1'b1) : dy_t;
    side1_next.r     = rsum[R_W-1:0];
  end

  assign l_sum = L_W'(sq_x) + L_W'(sq_y);

  // attach the overlap decision to the sideband
  always_comb begin
    side3_next     = side2;
    side3_next.hit = (l_sum < L_W'(sq_r));
  end

  // hold valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // advance payload: diff, squares, compare
  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side1_next;
      side2 <= side1;
      sq_x  <= side1.ux * side1.ux;
      sq_y  <= side1.uy * side1.uy;
      sq_r  <= side1.r * side1.r;
      side3 <= side3_next;
      rad   <= RAD_W'(l_sum) << (2 * SQRT_GUARD);
    end
  end

  assign out_valid = v3;
  assign out_side  = side3;
  assign out_rad   = rad;

endmodule

// ----- rtl/clc_sqrt_stage.sv -----
// ----------------------------------------------------------------------------
// clc_sqrt_stage
// One registered step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module clc_sqrt_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  clc_pkg::side_t             in_side,
  input  logic [clc_pkg::RAD_W-1:0]  in_rad,
  input  logic [clc_pkg::REM_W-1:0]  in_rem,
  input  logic [clc_pkg::ROOT_W-1:0] in_root,
  output logic                       out_valid,
  output clc_pkg::side_t             out_side,
  output logic [clc_pkg::RAD_W-1:0]  out_rad,
  output logic [clc_pkg::REM_W-1:0]  out_rem,
  output logic [clc_pkg::ROOT_W-1:0] out_root
);
  import clc_pkg::*;

  logic [REM_W+1:0] cat;
  logic [REM_W+1:0] trial;
  logic             take;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    cat   = {in_rem, in_rad[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({in_root, 2'b01});
    take  = (cat >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_rad  <= in_rad << 2;
      out_rem  <= take ? REM_W'(cat - trial) : REM_W'(cat);
      out_root <= {in_root[ROOT_W-2:0], take};
    end
  end

endmodule

// ----- rtl/clc_div_stage.sv -----
// ----------------------------------------------------------------------------
// clc_div_stage
// One registered restoring-division step for both normal components.
// ----------------------------------------------------------------------------
module clc_div_stage #(
  parameter int QW = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  clc_pkg::side_t             in_side,
  input  logic [clc_pkg::ROOT_W-1:0] in_s,
  input  logic [clc_pkg::DREM_W-1:0] in_rem_x,
  input  logic [clc_pkg::DREM_W-1:0] in_rem_y,
  input  logic [QW-1:0]              in_qx,
  input  logic [QW-1:0]              in_qy,
  output logic                       out_valid,
  output clc_pkg::side_t             out_side,
  output logic [clc_pkg::ROOT_W-1:0] out_s,
  output logic [clc_pkg::DREM_W-1:0] out_rem_x,
  output logic [clc_pkg::DREM_W-1:0] out_rem_y,
  output logic [QW-1:0]              out_qx,
  output logic [QW-1:0]              out_qy
);
  import clc_pkg::*;

  logic [DREM_W:0] tx, ty, sd;
  logic            bx, by;

  // shift in a zero bit and subtract the divisor where it fits
  always_comb begin
    tx = {in_rem_x, 1'b0};
    ty = {in_rem_y, 1'b0};
    sd = (DREM_W+1)'(in_s);
    bx = (tx >= sd);
    by = (ty >= sd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side  <= in_side;
      out_s     <= in_s;
      out_rem_x <= bx ? DREM_W'(tx - sd) : DREM_W'(tx);
      out_rem_y <= by ? DREM_W'(ty - sd) : DREM_W'(ty);
      out_qx    <= {in_qx[QW-2:0], bx};
      out_qy    <= {in_qy[QW-2:0], by};
    end
  end

endmodule

// ----- test/circle_overlap_contact_core_tb.sv -----
// ----------------------------------------------------------------------------
// circle_overlap_contact_core_tb
// Checks hit flag, unit normal and penetration depth of the circle contact
// pipeline against an in-bench fixed-point predictor, under random bursts
// on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module circle_overlap_contact_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB       = 24;
  localparam int NFB      = 14;
  localparam int GUARD    = 7;
  localparam int N_RANDOM = 1500;
  localparam int WD_LIMIT = 20000;
  localparam int LATENCY  = 52;

  typedef struct {
    logic [CB-1:0] ax, ay, bx, by;
    logic [CB-2:0] ar, br;
  } pair_t;

  typedef struct {
    logic        hit;
    logic [15:0] nx, ny;
    logic [23:0] depth;
  } contact_t;

  // integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] normal_part(longint d, longint unsigned s);
    longint unsigned a, q;
    a = (d < 0) ? longint'(-d) : longint'(d);
    q = (((a << (NFB + GUARD + 1)) / s) + 1) >> 1;
    if (q > (64'd1 << NFB)) q = 64'd1 << NFB;
    return (d < 0) ? 16'(-longint'(q)) : 16'(q);
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint dx, dy;
    longint unsigned r, ux, uy, l, s;
    dx = longint'($signed(p.bx)) - longint'($signed(p.ax));
    dy = longint'($signed(p.by)) - longint'($signed(p.ay));
    r  = longint'(p.ar) + longint'(p.br);
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    l  = ux * ux + uy * uy;
    c = '{hit: 1'b0, nx: '0, ny: '0, depth: '0};
    if (l < r * r) begin
      s = root_floor(l << (2 * GUARD));
      c.hit = 1'b1;
      if (s != 0) begin
        c.nx = normal_part(dx, s);
        c.ny = normal_part(dy, s);
      end
      c.depth = 24'(r - (s >> GUARD));
    end
    return c;
  endfunction

  class contact_scoreboard;
    contact_t pending[$];
    int errors;
    int hits;
    int checked;

    function void note_pair(pair_t p);
      pending.push_back(predict_contact(p));
    endfunction

    function void check_contact(contact_t got);
      contact_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.hit) hits++;
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.nx !== want.nx) begin
        $error("normal_x: expected %0d got %0d", $signed(want.nx), $signed(got.nx));
        errors++;
      end
      if (got.ny !== want.ny) begin
        $error("normal_y: expected %0d got %0d", $signed(want.ny), $signed(got.ny));
        errors++;
      end
      if (got.depth !== want.depth) begin
        $error("depth: expected %0d got %0d", want.depth, got.depth);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CB-1:0] first_center_x = '0, first_center_y = '0;
  logic [CB-1:0] second_center_x = '0, second_center_y = '0;
  logic [CB-2:0] first_radius = '0, second_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [15:0] normal_x, normal_y;
  logic [23:0] depth;

  contact_scoreboard board = new();
  pair_t stim_q[$];
  int idle_cycles = 0;
  bit stall_free = 1'b0;

  always #5 clk = ~clk;

  circle_overlap_contact_core dut (.*);

  // note accepted pairs and check result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_pair('{ax: first_center_x, ay: first_center_y, ar: first_radius,
                          bx: second_center_x, by: second_center_y, br: second_radius});
      if (out_valid && out_ready)
        board.check_contact('{hit: hit, nx: normal_x, ny: normal_y, depth: depth});
    end
  end

  // stall the receiver at random
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (stall_free) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 2 ? 1'b0 : 1'b0);
  end

  // watchdog on beats of either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic pair_t mk(int ax, int ay, int ar, int bx, int by, int br);
    pair_t p;
    p.ax = CB'(ax); p.ay = CB'(ay); p.ar = (CB-1)'(ar);
    p.bx = CB'(bx); p.by = CB'(by); p.br = (CB-1)'(br);
    return p;
  endfunction

  function automatic logic [CB-1:0] rand_coord();
    return CB'($urandom);
  endfunction

  // mostly near pairs so hits are frequent; some coincident centres and some wide-range noise
  function automatic pair_t rand_pair();
    pair_t p;
    int unsigned sel, span;
    sel = $urandom_range(0, 9);
    p.ax = rand_coord(); p.ay = rand_coord();
    p.ar = (CB-1)'($urandom); p.br = (CB-1)'($urandom);
    if (sel < 7) begin
      span = 1 << $urandom_range(1, 22);
      p.ar = (CB-1)'($urandom_range(0, span));
      p.br = (CB-1)'($urandom_range(0, span));
      p.bx = p.ax + CB'($urandom_range(0, 2 * span) - span);
      p.by = p.ay + CB'($urandom_range(0, 2 * span) - span);
    end else if (sel == 7) begin
      p.bx = p.ax; p.by = p.ay;
    end else begin
      p.bx = rand_coord(); p.by = rand_coord();
    end
    return p;
  endfunction

  // send queued pairs in bursts with random gaps
  task automatic send_all();
    int burst;
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && stim_q.size() > 0) begin
        pair_t p;
        p = stim_q.pop_front();
        in_valid <= 1'b1;
        first_center_x <= p.ax; first_center_y <= p.ay; first_radius <= p.ar;
        second_center_x <= p.bx; second_center_y <= p.by; second_radius <= p.br;
        do @(posedge clk); while (!in_ready);
        burst--;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  endtask

  initial begin
    int drain;
    localparam int MX = 8388607;
    localparam int MN = -8388608;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, coincident centres, zero radii, touching, axis cases
    stim_q.push_back(mk(0, 0, 0, 0, 0, 0));
    stim_q.push_back(mk(0, 0, 1, 0, 0, 0));
    stim_q.push_back(mk(5, 5, MX, 5, 5, MX));
    stim_q.push_back(mk(MN, MN, MX, MX, MX, MX));
    stim_q.push_back(mk(MX, MX, MX, MN, MN, MX));
    stim_q.push_back(mk(MN, 0, MX, MX, 0, MX));
    stim_q.push_back(mk(0, MX, MX, 0, MN, MX));
    stim_q.push_back(mk(0, 0, 100, 300, 400, 400));
    stim_q.push_back(mk(0, 0, 100, 300, 400, 401));
    stim_q.push_back(mk(0, 0, 256, 256, 0, 256));
    stim_q.push_back(mk(0, 0, 256, -256, 0, 256));
    stim_q.push_back(mk(0, 0, 256, 0, -256, 256));
    stim_q.push_back(mk(0, 0, 1, 1, 0, 1));
    stim_q.push_back(mk(0, 0, 1, 1, 1, 1));
    stim_q.push_back(mk(MN, MN, 0, MN, MN, 0));
    stim_q.push_back(mk(MX, MN, 3, MX, MN, 0));
    stim_q.push_back(mk(-1, -1, MX, 1, 1, 0));
    stim_q.push_back(mk(1000, -2000, 5000, -3000, 1000, 7000));
    stim_q.push_back(mk(0, 0, MX, MX, 0, 0));
    stim_q.push_back(mk(0, 0, MX, MX, 0, 1));
    send_all();

    for (int i = 0; i < N_RANDOM; i++) stim_q.push_back(rand_pair());
    send_all();

    // drain remaining results with the receiver open
    stall_free = 1'b1;
    drain = 0;
    while (board.pending.size() > 0 && drain < 100 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    repeat (2 * LATENCY) @(posedge clk);

    $display("contact pairs checked: %0d, overlaps among them: %0d",
             board.checked, board.hits);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("results left unmatched: %0d", board.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
